@@ sv/clt_pkg.sv @@
package clt_pkg;

    localparam logic [3:0] MAX_ARGS  = 4'd8;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;

    typedef enum logic [2:0] {
        MODE_IDLE        = 3'd0,
        MODE_AFTER_QUOTE = 3'd1,
        MODE_QUOTE_START = 3'd2,
        MODE_QUOTE_BODY  = 3'd3,
        MODE_TOKEN       = 3'd4,
        MODE_DONE        = 3'd5
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t  scan_mode;
        logic [7:0]  open_quote;
        logic [3:0]  args_seen;
    } scan_state_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        arg_start;
        logic        arg_end;
        logic [3:0]  arg_index;
        logic        line_done;
        logic [3:0]  arg_count;
    } scan_result_t;

endpackage

@@ sv/clt_step.sv @@
module clt_step (
    input  logic [7:0]            in_char,
    input  clt_pkg::scan_state_t  state,
    output clt_pkg::scan_state_t  state_next,
    output clt_pkg::scan_result_t result
);

    clt_pkg::scan_mode_t mode;
    logic                is_delim;
    logic                is_quote;
    logic                idle_like;
    logic [3:0]          bumped;

    assign is_delim = (in_char == clt_pkg::CHAR_LF) || (in_char == clt_pkg::CHAR_CR) ||
                      (in_char == clt_pkg::CHAR_TAB) || (in_char == clt_pkg::CHAR_SPACE) ||
                      (in_char == clt_pkg::CHAR_SLASH);
    assign is_quote = (in_char == clt_pkg::CHAR_SQUOTE) ||
                      (in_char == clt_pkg::CHAR_DQUOTE) || (in_char == clt_pkg::CHAR_TAB);
    assign bumped   = (state.args_seen == clt_pkg::COUNT_MAX) ? clt_pkg::COUNT_MAX
                                                             : state.args_seen + 4'd1;

    always_comb
    begin
        mode              = state.scan_mode;
        state_next        = state;
        result.out_char   = in_char;
        result.arg_start  = 1'b0;
        result.arg_end    = 1'b0;
        result.arg_index  = 4'd0;
        result.line_done  = 1'b0;
        result.arg_count  = state.args_seen;
        idle_like         = 1'b0;

        // quoted argument begins on the character after the opening quote
        if (mode == clt_pkg::MODE_QUOTE_START)
        begin
            result.arg_start = 1'b1;
            result.arg_index = state.args_seen - 4'd1;
            mode             = clt_pkg::MODE_QUOTE_BODY;
        end

        if (in_char == clt_pkg::CHAR_NUL)
        begin
            result.line_done      = 1'b1;
            state_next.scan_mode  = clt_pkg::MODE_IDLE;
            state_next.open_quote = 8'd0;
            state_next.args_seen  = 4'd0;
        end
        else
        begin
            unique case (mode)
                clt_pkg::MODE_AFTER_QUOTE:
                begin
                    idle_like = 1'b1;
                end
                clt_pkg::MODE_TOKEN:
                begin
                    if (is_delim)
                    begin
                        result.out_char = 8'd0;
                        result.arg_end  = 1'b1;
                        mode            = clt_pkg::MODE_IDLE;
                    end
                end
                clt_pkg::MODE_QUOTE_BODY:
                begin
                    if (in_char == state.open_quote)
                    begin
                        result.out_char = 8'd0;
                        result.arg_end  = 1'b1;
                        mode            = clt_pkg::MODE_AFTER_QUOTE;
                    end
                end
                clt_pkg::MODE_DONE:
                begin
                    result.line_done = 1'b1;
                end
                default:
                begin
                    // idle and unused codes
                    if (is_quote)
                    begin
                        state_next.args_seen = bumped;
                        if (state.args_seen >= clt_pkg::MAX_ARGS)
                        begin
                            mode             = clt_pkg::MODE_DONE;
                            result.line_done = 1'b1;
                        end
                        else
                        begin
                            state_next.open_quote = in_char;
                            mode                  = clt_pkg::MODE_QUOTE_START;
                        end
                    end
                    else
                    begin
                        idle_like = 1'b1;
                    end
                end
            endcase

            if (idle_like)
            begin
                if (is_delim)
                begin
                    mode = clt_pkg::MODE_IDLE;
                end
                else
                begin
                    result.arg_start     = 1'b1;
                    result.arg_index     = state.args_seen;
                    state_next.args_seen = bumped;
                    if (state.args_seen >= clt_pkg::MAX_ARGS)
                    begin
                        mode             = clt_pkg::MODE_DONE;
                        result.line_done = 1'b1;
                    end
                    else
                    begin
                        mode = clt_pkg::MODE_TOKEN;
                    end
                end
            end

            state_next.scan_mode = mode;
            result.arg_count     = state_next.args_seen;
        end
    end

endmodule

@@ sv/command_line_tokenizer.sv @@
// Splits a command line into arguments, one character per transaction. Every input
// character yields exactly one output transaction carrying the character as rewritten
// (zero where a delimiter ended a token or a closing quote stood), argument start and
// end flags, the index of a starting argument and the running count; tlast marks the
// end of line (zero character) or an exceeded argument limit. The block takes one
// character per cycle while the output is not stalled: the scan state update is a short
// combinational step, and a single output register holds the result, so input is
// taken whenever that register is empty or being drained in the same cycle.
module command_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char[7:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_char[7:0], arg_index[11:8], arg_count[15:12]
    output logic [1:0]  m_tuser,   // arg_start[0], arg_end[1]
    output logic        m_tlast    // line_done
);

    clt_pkg::scan_state_t  state_reg;
    clt_pkg::scan_state_t  state_next;
    clt_pkg::scan_result_t result_next;
    clt_pkg::scan_result_t out_reg;
    logic                  out_valid_reg;
    logic                  accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    clt_step u_step (
        .in_char    (s_tdata),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.scan_mode  <= clt_pkg::MODE_IDLE;
            state_reg.open_quote <= 8'd0;
            state_reg.args_seen  <= 4'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.arg_count, out_reg.arg_index, out_reg.out_char};
    assign m_tuser  = {out_reg.arg_end, out_reg.arg_start};
    assign m_tlast  = out_reg.line_done;

    // a rewritten terminator is always a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[7:0] == 8'd0))
    else $error("arg_end without zero character");

    // any mode inside or after an argument implies at least one counted argument
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.scan_mode != clt_pkg::MODE_IDLE) |-> (state_reg.args_seen != 4'd0))
    else $error("argument mode with zero count");

    // end of line returns the scanner to the start of a fresh line
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tdata == 8'd0)) |=>
        ((state_reg.scan_mode == clt_pkg::MODE_IDLE) && (state_reg.args_seen == 4'd0)))
    else $error("scan state not cleared after end of line");

endmodule

@@ tb/sv/clt_stream_checker.sv @@
module clt_stream_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char[7:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // out_char[7:0], arg_index[11:8], arg_count[15:12]
    input  logic [1:0]  m_tuser,   // arg_start[0], arg_end[1]
    input  logic        m_tlast,   // line_done

    output int unsigned failures,
    output int unsigned outstanding
);

    clt_pkg::scan_mode_t  tok_mode  = clt_pkg::MODE_IDLE;
    logic [7:0]           tok_quote = clt_pkg::CHAR_NUL;
    logic [3:0]           tok_args  = '0;

    clt_pkg::scan_result_t scanned_chars [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    function automatic bit splits_token(input logic [7:0] c);
        return c == clt_pkg::CHAR_LF || c == clt_pkg::CHAR_CR || c == clt_pkg::CHAR_TAB ||
               c == clt_pkg::CHAR_SPACE || c == clt_pkg::CHAR_SLASH;
    endfunction

    function automatic bit opens_quote(input logic [7:0] c);
        return c == clt_pkg::CHAR_SQUOTE || c == clt_pkg::CHAR_DQUOTE ||
               c == clt_pkg::CHAR_TAB;
    endfunction

    function automatic logic [3:0] count_up(input logic [3:0] n);
        return (n >= clt_pkg::COUNT_MAX) ? clt_pkg::COUNT_MAX : n + 4'd1;
    endfunction

    // advances the scan state by one character and returns the expected result for it
    function automatic clt_pkg::scan_result_t tokenize_char(input logic [7:0] c);
        clt_pkg::scan_result_t r;
        clt_pkg::scan_mode_t   m;
        r          = '0;
        r.out_char = c;
        m          = tok_mode;
        // a quoted argument begins on the character after its opening quote
        if (m == clt_pkg::MODE_QUOTE_START)
        begin
            r.arg_start = 1'b1;
            r.arg_index = tok_args - 4'd1;
            m           = clt_pkg::MODE_QUOTE_BODY;
        end
        if (c == clt_pkg::CHAR_NUL)
        begin
            r.line_done = 1'b1;
            r.arg_count = tok_args;
            tok_mode    = clt_pkg::MODE_IDLE;
            tok_quote   = clt_pkg::CHAR_NUL;
            tok_args    = '0;
        end
        else
        begin
            if (m == clt_pkg::MODE_IDLE && opens_quote(c))
            begin
                tok_args = (tok_args >= clt_pkg::MAX_ARGS) ? count_up(tok_args) : tok_args;
                if (tok_args > clt_pkg::MAX_ARGS)
                begin
                    // quoted argument past the limit is dropped
                    m           = clt_pkg::MODE_DONE;
                    r.line_done = 1'b1;
                end
                else
                begin
                    tok_quote = c;
                    tok_args  = count_up(tok_args);
                    m         = clt_pkg::MODE_QUOTE_START;
                end
            end
            else if (m == clt_pkg::MODE_IDLE || m == clt_pkg::MODE_AFTER_QUOTE)
            begin
                if (splits_token(c))
                    m = clt_pkg::MODE_IDLE;
                else
                begin
                    r.arg_start = 1'b1;
                    r.arg_index = tok_args;
                    tok_args    = count_up(tok_args);
                    if (r.arg_index >= clt_pkg::MAX_ARGS)
                    begin
                        m           = clt_pkg::MODE_DONE;
                        r.line_done = 1'b1;
                    end
                    else
                        m = clt_pkg::MODE_TOKEN;
                end
            end
            else if (m == clt_pkg::MODE_TOKEN)
            begin
                if (splits_token(c))
                begin
                    r.out_char = clt_pkg::CHAR_NUL;
                    r.arg_end  = 1'b1;
                    m          = clt_pkg::MODE_IDLE;
                end
            end
            else if (m == clt_pkg::MODE_QUOTE_BODY)
            begin
                if (c == tok_quote)
                begin
                    r.out_char = clt_pkg::CHAR_NUL;
                    r.arg_end  = 1'b1;
                    m          = clt_pkg::MODE_AFTER_QUOTE;
                end
            end
            else
                r.line_done = 1'b1;
            tok_mode    = m;
            r.arg_count = tok_args;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clt_pkg::scan_result_t want;
        if (!rst_n)
        begin
            tok_mode  = clt_pkg::MODE_IDLE;
            tok_quote = clt_pkg::CHAR_NUL;
            tok_args  = '0;
            scanned_chars.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                scanned_chars.push_back(tokenize_char(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (scanned_chars.size() == 0)
                begin
                    failures++;
                    $error("output transaction with no character pending");
                end
                else
                begin
                    want = scanned_chars.pop_front();
                    check_field("out_char", want.out_char, m_tdata[7:0]);
                    check_field("arg_start", want.arg_start, m_tuser[0]);
                    check_field("arg_end", want.arg_end, m_tuser[1]);
                    check_field("arg_index", want.arg_index, m_tdata[11:8]);
                    check_field("line_done", want.line_done, m_tlast);
                    check_field("arg_count", want.arg_count, m_tdata[15:12]);
                end
            end
            outstanding <= scanned_chars.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;

    localparam int RANDOM_CHARS = 1500;
    localparam int HOLD_CYCLES  = 60;

    // quote, empty tab quote, quote on line end, open quote at line end,
    // high and low bytes in tokens, token ended by the line end, empty line
    localparam logic [7:0] OPENING_CHARS [21] = '{
        clt_pkg::CHAR_SQUOTE, 8'h78, clt_pkg::CHAR_SQUOTE, 8'h79, clt_pkg::CHAR_SLASH,
        clt_pkg::CHAR_NUL,
        clt_pkg::CHAR_TAB, clt_pkg::CHAR_TAB, clt_pkg::CHAR_SPACE, clt_pkg::CHAR_NUL,
        clt_pkg::CHAR_DQUOTE, clt_pkg::CHAR_NUL,
        clt_pkg::CHAR_DQUOTE, 8'h61, clt_pkg::CHAR_NUL,
        8'hFF, 8'h01, clt_pkg::CHAR_LF, 8'h7F, clt_pkg::CHAR_NUL,
        clt_pkg::CHAR_NUL
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int unsigned failures;
    int unsigned outstanding;
    int          chars_sent   = 0;
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;

    command_line_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    clt_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("[command_line_tokenizer] ERROR");
        $finish;
    end

    function automatic bit is_gap(input logic [7:0] c);
        return c == clt_pkg::CHAR_LF || c == clt_pkg::CHAR_CR || c == clt_pkg::CHAR_TAB ||
               c == clt_pkg::CHAR_SPACE || c == clt_pkg::CHAR_SLASH;
    endfunction

    function automatic logic [7:0] gap_char();
        case ($urandom_range(3))
            0:       return clt_pkg::CHAR_SPACE;
            1:       return clt_pkg::CHAR_CR;
            2:       return clt_pkg::CHAR_LF;
            default: return clt_pkg::CHAR_SLASH;
        endcase
    endfunction

    // first character of a plain token must not look like an opening quote
    function automatic logic [7:0] word_char(input bit first);
        logic [7:0] c;
        if ($urandom_range(99) < 75)
            return 8'h61 + 8'($urandom_range(25));
        do
            c = 8'($urandom_range(1, 255));
        while (is_gap(c) ||
               (first && (c == clt_pkg::CHAR_SQUOTE || c == clt_pkg::CHAR_DQUOTE)));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c);
        while (!steady && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line();
        int         n_args;
        int         len;
        logic [7:0] q;
        logic [7:0] c;
        bit         cut;
        // some lines are plain noise
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 24))
                send_char(8'($urandom_range(255)));
            send_char(clt_pkg::CHAR_NUL);
            return;
        end
        n_args = ($urandom_range(99) < 25) ? $urandom_range(7, 12) : $urandom_range(0, 6);
        repeat ($urandom_range(0, 2))
            send_char(gap_char());
        for (int a = 0; a < n_args; a++)
        begin
            // last argument sometimes left open up to the line end
            cut = (a == n_args - 1) && ($urandom_range(99) < 15);
            len = $urandom_range(0, 6);
            if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(2))
                    0:       q = clt_pkg::CHAR_SQUOTE;
                    1:       q = clt_pkg::CHAR_DQUOTE;
                    default: q = clt_pkg::CHAR_TAB;
                endcase
                send_char(q);
                repeat (len)
                begin
                    if ($urandom_range(99) < 70)
                        c = 8'h61 + 8'($urandom_range(25));
                    else
                        do
                            c = 8'($urandom_range(1, 255));
                        while (c == q);
                    send_char(c);
                end
                if (!cut)
                    send_char(q);
            end
            else
            begin
                send_char(word_char(1'b1));
                repeat (len)
                    send_char(word_char(1'b0));
                if (!cut)
                    send_char(($urandom_range(4) == 0) ? clt_pkg::CHAR_TAB : gap_char());
            end
            if (!cut)
                repeat ($urandom_range(0, 2))
                    send_char(gap_char());
        end
        send_char(clt_pkg::CHAR_NUL);
    endtask

    // output side: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 18);
        end
    end

    initial
    begin
        bit held;
        held     = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING_CHARS[i])
            send_char(OPENING_CHARS[i]);

        while (chars_sent < $size(OPENING_CHARS) + RANDOM_CHARS)
        begin
            steady = (chars_sent >= 700 && chars_sent < 1000);
            if (!held && chars_sent >= 300)
            begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            send_line();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("[command_line_tokenizer] OK");
        else
            $display("[command_line_tokenizer] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/clt_pkg.sv
sv/clt_step.sv
sv/command_line_tokenizer.sv
tb/sv/clt_stream_checker.sv
tb/sv/tb.sv
